// ----- design/sxg_pkg.sv -----
// Shared types and constants for the horizontal Sobel gradient unit.
// Used by the RAM-fed front end, the queue, the back end and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sxg_pkg;

	// Largest image side that the line buffers hold.
	localparam int MAX_SIDE    = 1024;
	// Pixel bits that take part in the arithmetic.
	localparam int PIXEL_BITS  = 8;
	// Fixed field widths of the interface.
	localparam int PIXEL_FIELD = 8;
	localparam int SIDE_BITS   = 11;
	localparam int GRAD_BITS   = 11;
	localparam logic [SIDE_BITS-1:0] SIDE_RESET = SIDE_BITS'(64);

	// Column index and row counter widths follow from the largest side.
	localparam int ADDR_BITS = $clog2(MAX_SIDE);
	localparam int ROW_BITS  = ADDR_BITS + 1;
	localparam int CMP_BITS  = (SIDE_BITS > ROW_BITS) ? SIDE_BITS : ROW_BITS;

	// One line buffer entry holds the two rows above the current one.
	localparam int LINE_BITS = 2 * PIXEL_BITS;

	// Sum width before the result is clipped to the gradient field.
	localparam int SUM_BITS = (PIXEL_BITS + 3 > GRAD_BITS) ? PIXEL_BITS + 3 : GRAD_BITS;

	// Queue between front and back end.
	localparam int QPTR_BITS   = 2;
	localparam int QUEUE_DEPTH = 1 << QPTR_BITS;

	typedef logic [PIXEL_BITS-1:0]      pix_t;
	typedef logic [2:0][PIXEL_BITS-1:0] column_t;

	typedef struct packed {
		logic [PIXEL_FIELD-1:0] pixel;
		logic                   flush;
	} pixel_in_t;

	typedef struct packed {
		logic signed [GRAD_BITS-1:0] gradient;
		logic                        frame_last;
	} pixel_out_t;

	// One pending result: left and right window columns, top row at index 0.
	typedef struct packed {
		logic    interior;
		logic    last;
		column_t left;
		column_t right;
	} q_entry_t;

endpackage

`default_nettype wire

// ----- design/sxg_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sxg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- design/sxg_front.sv -----
// Front end: takes pixels, tracks frame position, keeps the line buffers and window.
// Classifies each item and pushes one queue entry per result. Uses sxg_pkg, sxg_ram.
`timescale 1ns / 1ps
`default_nettype none

module sxg_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [sxg_pkg::SIDE_BITS-1:0] cfg_wr_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire sxg_pkg::pixel_in_t           in_data,
	output logic                              q_push,
	input  wire logic                         q_full,
	output sxg_pkg::q_entry_t                 q_entry
);

	logic [sxg_pkg::SIDE_BITS-1:0] side_q;
	logic [sxg_pkg::ROW_BITS-1:0]  in_row_q;
	logic [sxg_pkg::ADDR_BITS-1:0] in_col_q;
	logic [sxg_pkg::ADDR_BITS-1:0] out_row_q;
	logic [sxg_pkg::ADDR_BITS-1:0] out_col_q;

	logic                          valid_s1;
	logic                          emit_s1;
	logic                          interior_s1;
	logic                          last_s1;
	sxg_pkg::pix_t                 pix_s1;
	logic [sxg_pkg::ADDR_BITS-1:0] addr_s1;
	logic                          byp_s1;
	logic [sxg_pkg::LINE_BITS-1:0] byp_data_s1;

	sxg_pkg::column_t              left_q;
	sxg_pkg::column_t              right_q;

	logic [sxg_pkg::CMP_BITS-1:0]  side_w;
	logic [sxg_pkg::ADDR_BITS-1:0] dm1;
	logic [sxg_pkg::ROW_BITS-1:0]  row_end;
	logic                          accept;
	logic                          advance;
	logic                          emit_now;
	logic                          interior_now;
	logic                          last_now;
	sxg_pkg::pix_t                 pix_now;
	logic [sxg_pkg::LINE_BITS-1:0] ram_rd;
	logic [sxg_pkg::LINE_BITS-1:0] line_rd;
	logic [sxg_pkg::LINE_BITS-1:0] line_wr;
	sxg_pkg::column_t              new_col;

	// Effective side minus one, with zero taken as one and oversize clipped.
	always_comb begin
		side_w = sxg_pkg::CMP_BITS'(side_q);
		if (side_q == '0) begin
			dm1 = '0;
		end else if (side_w > sxg_pkg::CMP_BITS'(sxg_pkg::MAX_SIDE)) begin
			dm1 = sxg_pkg::ADDR_BITS'(sxg_pkg::MAX_SIDE - 1);
		end else begin
			dm1 = sxg_pkg::ADDR_BITS'(side_w - sxg_pkg::CMP_BITS'(1));
		end
		row_end = sxg_pkg::ROW_BITS'(dm1) + sxg_pkg::ROW_BITS'(2);
	end

	assign advance  = valid_s1 && (!emit_s1 || !q_full);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	always_comb begin
		pix_now      = in_data.flush ? '0 : in_data.pixel[sxg_pkg::PIXEL_BITS-1:0];
		emit_now     = (in_row_q >= sxg_pkg::ROW_BITS'(2)) ||
		               (in_row_q == sxg_pkg::ROW_BITS'(1) && in_col_q != '0);
		interior_now = out_row_q != '0 && out_row_q < dm1 &&
		               out_col_q != '0 && out_col_q < dm1;
		last_now     = out_row_q == dm1 && out_col_q == dm1;
	end

	// Frame position counters; a register write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q    <= sxg_pkg::SIDE_RESET;
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (cfg_wr_en) begin
			side_q    <= cfg_wr_data;
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (accept) begin
			if (in_row_q >= row_end) begin
				in_row_q  <= '0;
				in_col_q  <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end else begin
				if (in_col_q >= dm1) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + sxg_pkg::ROW_BITS'(1);
				end else begin
					in_col_q <= in_col_q + sxg_pkg::ADDR_BITS'(1);
				end
				if (emit_now) begin
					if (out_col_q >= dm1) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + sxg_pkg::ADDR_BITS'(1);
					end else begin
						out_col_q <= out_col_q + sxg_pkg::ADDR_BITS'(1);
					end
				end
			end
		end
	end

	// Line buffer entry: upper row in the high half, middle row in the low half.
	sxg_ram #(
		.WIDTH(sxg_pkg::LINE_BITS),
		.DEPTH(sxg_pkg::MAX_SIDE)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (advance),
		.wr_addr(addr_s1),
		.wr_data(line_wr),
		.rd_en  (accept),
		.rd_addr(in_col_q),
		.rd_data(ram_rd)
	);

	// A one-column frame reads the entry that is being written in the same cycle.
	always_comb begin
		line_rd    = byp_s1 ? byp_data_s1 : ram_rd;
		line_wr    = {line_rd[sxg_pkg::PIXEL_BITS-1:0], pix_s1};
		new_col[0] = line_rd[sxg_pkg::LINE_BITS-1:sxg_pkg::PIXEL_BITS];
		new_col[1] = line_rd[sxg_pkg::PIXEL_BITS-1:0];
		new_col[2] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1     <= emit_now;
			interior_s1 <= interior_now;
			last_s1     <= last_now;
			pix_s1      <= pix_now;
			addr_s1     <= in_col_q;
			byp_s1      <= advance && (addr_s1 == in_col_q);
			byp_data_s1 <= line_wr;
		end
		if (advance) begin
			left_q  <= right_q;
			right_q <= new_col;
		end
	end

	// Window before the shift: oldest column on the left, new column on the right.
	assign q_push           = advance && emit_s1;
	assign q_entry.interior = interior_s1;
	assign q_entry.last     = last_s1;
	assign q_entry.left     = left_q;
	assign q_entry.right    = new_col;

endmodule

`default_nettype wire

// ----- design/sxg_queue.sv -----
// Short first-in first-out queue of pending results between front and back end.
// Uses sxg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sxg_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire sxg_pkg::q_entry_t  push_entry,
	output logic                    full,
	input  wire logic               pop,
	output logic                    valid,
	output sxg_pkg::q_entry_t       head
);

	sxg_pkg::q_entry_t             slot_q [sxg_pkg::QUEUE_DEPTH];
	logic [sxg_pkg::QPTR_BITS-1:0] wr_ptr_q;
	logic [sxg_pkg::QPTR_BITS-1:0] rd_ptr_q;
	logic [sxg_pkg::QPTR_BITS:0]   count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full    = count_q == (sxg_pkg::QPTR_BITS + 1)'(sxg_pkg::QUEUE_DEPTH);
	assign valid   = count_q != '0;
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + sxg_pkg::QPTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + sxg_pkg::QPTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (sxg_pkg::QPTR_BITS + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (sxg_pkg::QPTR_BITS + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

// ----- design/sxg_back.sv -----
// Back end: weights the window columns into the gradient and holds the result register.
// Uses sxg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sxg_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire sxg_pkg::q_entry_t  q_head,
	output logic                    q_pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output sxg_pkg::pixel_out_t     out_data
);

	localparam logic signed [sxg_pkg::SUM_BITS-1:0] SAT_HI =
		sxg_pkg::SUM_BITS'((1 << (sxg_pkg::GRAD_BITS - 1)) - 1);
	localparam logic signed [sxg_pkg::SUM_BITS-1:0] SAT_LO =
		-sxg_pkg::SUM_BITS'(1 << (sxg_pkg::GRAD_BITS - 1));

	logic signed [sxg_pkg::SUM_BITS-1:0] diff [3];
	logic signed [sxg_pkg::SUM_BITS-1:0] sum;
	logic signed [sxg_pkg::SUM_BITS-1:0] clipped;
	sxg_pkg::pixel_out_t                 result;
	logic                                out_valid_q;
	sxg_pkg::pixel_out_t                 out_data_q;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			diff[r] = sxg_pkg::SUM_BITS'(q_head.right[r]) - sxg_pkg::SUM_BITS'(q_head.left[r]);
		end
		// Middle row carries weight two.
		sum = diff[0] + (diff[1] <<< 1) + diff[2];
		if (sum > SAT_HI) begin
			clipped = SAT_HI;
		end else if (sum < SAT_LO) begin
			clipped = SAT_LO;
		end else begin
			clipped = sum;
		end
		result.gradient   = q_head.interior ? sxg_pkg::GRAD_BITS'(clipped) : '0;
		result.frame_last = q_head.last;
	end

	assign q_pop = q_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ----- design/sobel_x_gradient_3x3_unit.sv -----
// Top level of the horizontal 3x3 Sobel gradient unit over a square raster stream.
// Depends on sxg_pkg, sxg_front, sxg_queue and sxg_back.
//
//   Channel   Direction  Handshake               Contents
//   in        input      in_valid / in_ready     pixel_in_t: pixel, flush
//   out       output     out_valid / out_ready   pixel_out_t: gradient, frame_last
//   cfg       input      cfg_wr_en               cfg_wr_data: side_length
//
// The unit accepts one request per clock cycle as long as the result queue has room.
// A request is registered in the front-end stage together with the line buffer RAM read;
// the window update pushes a queue entry, and the back end registers the gradient sum.
// Reset is asynchronous and needs no clearing pass: line buffer entries that were never
// written only reach border results, which are forced to zero.
// When out_ready is low, the four-entry queue absorbs results before in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module sobel_x_gradient_3x3_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [sxg_pkg::SIDE_BITS-1:0] cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire sxg_pkg::pixel_in_t            in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output sxg_pkg::pixel_out_t                out_data
);

	// Handshake between the front end and the queue, and between the queue and the back.
	logic              q_push;
	logic              q_full;
	sxg_pkg::q_entry_t q_push_entry;
	logic              q_pop;
	logic              q_valid;
	sxg_pkg::q_entry_t q_head;

	// The front end tracks the frame position, reads and updates the line buffers and
	// builds the window. Each request that completes a window pushes one entry.
	sxg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.q_push     (q_push),
		.q_full     (q_full),
		.q_entry    (q_push_entry)
	);

	// The queue lets the output side stall without stopping the input side at once.
	sxg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(q_push_entry),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	// The back end sums the weighted column differences and registers the result.
	sxg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// The final pixel of a frame is a corner, so its gradient must be zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_last |-> out_data.gradient == '0)
		else $error("frame_last result with a nonzero gradient");

	// The input side only stalls because the queue is full.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_full)
		else $error("input stalled while the queue has room");

	// Eight-bit pixels keep the gradient within plus or minus 1020.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.gradient <= 11'sd1020 && out_data.gradient >= -11'sd1020))
		else $error("gradient outside the reachable range");

	// A push never meets a full queue, or a result would be lost.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_full && !q_pop |=> !(q_push && q_full))
		else $error("push into a full queue");

endmodule

`default_nettype wire
